@@ rtl/screlu_dot_product_output_macros.svh @@
// ----------------------------------------------------------------------------
// screlu dot product output assertion macros
// shared property templates for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SCRELU_DOT_PRODUCT_OUTPUT_MACROS_SVH
`define SCRELU_DOT_PRODUCT_OUTPUT_MACROS_SVH

// same-cycle implication
`define SDPO_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDPO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sdpo_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpo_pkg
// types and constants shared by the screlu output layer modules
// ----------------------------------------------------------------------------
`default_nettype none

package sdpo_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_W   = 48;
   localparam int DVS_W   = 26;
   localparam int DIV_CNT_W = 6;

   localparam logic [14:0] CLAMP_MAX_RESET    = 15'd255;
   localparam logic [10:0] BIAS_QUANT_RESET   = 11'd64;
   localparam logic [12:0] OUTPUT_SCALE_RESET = 13'd400;
   localparam logic [31:0] OUTPUT_BIAS_RESET  = 32'd0;

   localparam logic SEL_SUM    = 1'b0;
   localparam logic SEL_SCALED = 1'b1;

   typedef enum logic [1:0] {
      CSR_CLAMP_MAX    = 2'd0,
      CSR_BIAS_QUANT   = 2'd1,
      CSR_OUTPUT_SCALE = 2'd2,
      CSR_OUTPUT_BIAS  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_DIV1,
      ST_SCALE,
      ST_START2,
      ST_DIV2
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear_sum;
      logic div_start;
      logic div_sel;
      logic load_t1;
      logic load_t2;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/screlu_dot_product_output.sv @@
// ----------------------------------------------------------------------------
// screlu_dot_product_output
// screlu output layer: clamp, square, weight and sum element pairs, then scale
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  own/other value, own/other weight, last
//   rsp      out        rsp_valid/rsp_ready  score
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// non-last pairs transfer one per cycle into a four-stage multiply-accumulate pipe
// after a last pair: pipe drain, then two serial radix-2 divisions with a scaling step between
// input is held off until the score is loaded
// the score register lets new pairs transfer while a score waits on rsp_ready
// synchronous reset returns the config registers to defaults and clears the running sum
// ----------------------------------------------------------------------------
`default_nettype none

module screlu_dot_product_output (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [15:0]               req_own_value,
   input  wire logic signed [15:0]               req_other_value,
   input  wire logic signed [15:0]               req_own_weight,
   input  wire logic signed [15:0]               req_other_weight,
   input  wire logic                             req_last,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [31:0]                    rsp_score,
   input  wire logic                             csr_write_enable,
   input  wire logic [sdpo_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sdpo_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   sdpo_pkg::cmd_type    cmd;
   sdpo_pkg::status_type status;

   sdpo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sdpo_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_own_value    (req_own_value),
      .req_other_value  (req_other_value),
      .req_own_weight   (req_own_weight),
      .req_other_weight (req_other_weight),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_score        (rsp_score)
   );

endmodule

`default_nettype wire

@@ rtl/sdpo_divider.sv @@
// ----------------------------------------------------------------------------
// sdpo_divider
// radix-2 restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sdpo_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [sdpo_pkg::DIV_W-1:0]     dividend,
   input  wire logic [sdpo_pkg::DVS_W-1:0]     divisor,
   output logic                                busy,
   output logic [sdpo_pkg::DIV_W-1:0]          quotient
);

   logic [sdpo_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [sdpo_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [sdpo_pkg::DVS_W-1:0]     dvs_ff, dvs_in;
   logic [sdpo_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                           busy_ff, busy_in;

   logic [sdpo_pkg::DVS_W:0]       shifted;
   logic [sdpo_pkg::DVS_W+1:0]     diff;
   logic                           borrow;

   assign shifted = {rem_ff, quo_ff[sdpo_pkg::DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign borrow  = diff[sdpo_pkg::DVS_W+1];

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
         count_in = sdpo_pkg::DIV_CNT_W'(sdpo_pkg::DIV_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = borrow ? shifted[sdpo_pkg::DVS_W-1:0] : diff[sdpo_pkg::DVS_W-1:0];
         quo_in = {quo_ff[sdpo_pkg::DIV_W-2:0], ~borrow};
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/sdpo_datapath.sv @@
// ----------------------------------------------------------------------------
// sdpo_datapath
// config registers, clamp-square-weight pipeline, running sum and final scaling
// ----------------------------------------------------------------------------
`default_nettype none

module sdpo_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sdpo_pkg::cmd_type                   cmd,
   output sdpo_pkg::status_type                     status,
   input  wire logic signed [15:0]                  req_own_value,
   input  wire logic signed [15:0]                  req_other_value,
   input  wire logic signed [15:0]                  req_own_weight,
   input  wire logic signed [15:0]                  req_other_weight,
   input  wire logic                                csr_write_enable,
   input  wire logic [sdpo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sdpo_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic signed [31:0]                       rsp_score
);

   // configuration
   logic [14:0] clamp_max_ff, clamp_max_in;
   logic [10:0] bias_quant_ff, bias_quant_in;
   logic [12:0] output_scale_ff, output_scale_in;
   logic [31:0] output_bias_ff, output_bias_in;
   logic [14:0] eff_clamp;
   logic [10:0] eff_quant;

   // pipeline
   logic               valid_a_ff, valid_b_ff, valid_c_ff;
   logic [14:0]        own_act_ff, other_act_ff;
   logic signed [15:0] own_wt_a_ff, other_wt_a_ff;
   logic [29:0]        own_sq_ff, other_sq_ff, own_sq_in, other_sq_in;
   logic signed [15:0] own_wt_b_ff, other_wt_b_ff;
   logic signed [46:0] own_prod_full, other_prod_full;
   logic [31:0]        own_prod_ff, other_prod_ff;
   logic [31:0]        sum_ff, sum_in;

   // final scaling
   logic [sdpo_pkg::DVS_W-1:0] divisor_prod_ff;
   logic [25:0]                divisor_prod_in;
   logic [31:0]                sum_mag;
   logic [46:0]                t2_ff, t2_mag;
   logic signed [47:0]         t2_full;
   logic signed [33:0]         t1_ff, t1_in;
   logic [32:0]                q1_mag, q1_signed;
   logic                       quot_neg_ff;
   logic [sdpo_pkg::DIV_W-1:0] div_dividend, quotient;
   logic [sdpo_pkg::DVS_W-1:0] div_divisor;
   logic                       div_busy;
   logic [31:0]                score_ff, score_in;

   function automatic logic [14:0] clamp_value(input logic [15:0] v, input logic [14:0] lim);
      logic [14:0] r;
      if (v[15]) begin
         r = '0;
      end else if (v[14:0] > lim) begin
         r = lim;
      end else begin
         r = v[14:0];
      end
      return r;
   endfunction

   assign eff_clamp = (clamp_max_ff == '0) ? 15'd1 : clamp_max_ff;
   assign eff_quant = (bias_quant_ff == '0) ? 11'd1 : bias_quant_ff;

   always_comb begin
      clamp_max_in    = clamp_max_ff;
      bias_quant_in   = bias_quant_ff;
      output_scale_in = output_scale_ff;
      output_bias_in  = output_bias_ff;
      if (csr_write_enable) begin
         case (sdpo_pkg::csr_index_type'(csr_index))
            sdpo_pkg::CSR_CLAMP_MAX:    clamp_max_in    = csr_write_data[14:0];
            sdpo_pkg::CSR_BIAS_QUANT:   bias_quant_in   = csr_write_data[10:0];
            sdpo_pkg::CSR_OUTPUT_SCALE: output_scale_in = csr_write_data[12:0];
            sdpo_pkg::CSR_OUTPUT_BIAS:  output_bias_in  = csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   assign own_sq_in       = {15'd0, own_act_ff} * {15'd0, own_act_ff};
   assign other_sq_in     = {15'd0, other_act_ff} * {15'd0, other_act_ff};
   assign own_prod_full   = $signed({1'b0, own_sq_ff}) * own_wt_b_ff;
   assign other_prod_full = $signed({1'b0, other_sq_ff}) * other_wt_b_ff;

   always_comb begin
      sum_in = sum_ff;
      if (cmd.clear_sum) begin
         sum_in = '0;
      end else if (valid_c_ff) begin
         sum_in = sum_ff + own_prod_ff + other_prod_ff;
      end
   end

   // divider operand selection
   assign divisor_prod_in = {11'd0, eff_clamp} * {15'd0, eff_quant};
   assign sum_mag         = sum_ff[31] ? (32'd0 - sum_ff) : sum_ff;
   assign t2_mag          = t2_ff[46] ? (47'd0 - t2_ff) : t2_ff;
   assign div_dividend    = (cmd.div_sel == sdpo_pkg::SEL_SCALED) ?
                            {1'b0, t2_mag} : {16'd0, sum_mag};
   assign div_divisor     = (cmd.div_sel == sdpo_pkg::SEL_SCALED) ?
                            divisor_prod_ff : {11'd0, eff_clamp};

   sdpo_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign q1_mag    = {1'b0, quotient[31:0]};
   assign q1_signed = quot_neg_ff ? (33'd0 - q1_mag) : q1_mag;
   assign t1_in     = $signed({q1_signed[32], q1_signed})
                    + $signed({{2{output_bias_ff[31]}}, output_bias_ff});
   assign t2_full   = t1_ff * $signed({1'b0, output_scale_ff});

   // saturate to 32-bit signed
   always_comb begin
      if (quot_neg_ff) begin
         if (quotient > 48'h0000_8000_0000) begin
            score_in = 32'h8000_0000;
         end else begin
            score_in = 32'd0 - quotient[31:0];
         end
      end else begin
         if (quotient > 48'h0000_7FFF_FFFF) begin
            score_in = 32'h7FFF_FFFF;
         end else begin
            score_in = quotient[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         own_act_ff    <= clamp_value(req_own_value, eff_clamp);
         other_act_ff  <= clamp_value(req_other_value, eff_clamp);
         own_wt_a_ff   <= req_own_weight;
         other_wt_a_ff <= req_other_weight;
      end
      own_sq_ff       <= own_sq_in;
      other_sq_ff     <= other_sq_in;
      own_wt_b_ff     <= own_wt_a_ff;
      other_wt_b_ff   <= other_wt_a_ff;
      own_prod_ff     <= own_prod_full[31:0];
      other_prod_ff   <= other_prod_full[31:0];
      divisor_prod_ff <= divisor_prod_in[sdpo_pkg::DVS_W-1:0];
      if (cmd.div_start) begin
         quot_neg_ff <= (cmd.div_sel == sdpo_pkg::SEL_SCALED) ? t2_ff[46] : sum_ff[31];
      end
      if (cmd.load_t1) begin
         t1_ff <= t1_in;
      end
      if (cmd.load_t2) begin
         t2_ff <= t2_full[46:0];
      end
      if (cmd.load_out) begin
         score_ff <= score_in;
      end
      if (reset) begin
         clamp_max_ff    <= sdpo_pkg::CLAMP_MAX_RESET;
         bias_quant_ff   <= sdpo_pkg::BIAS_QUANT_RESET;
         output_scale_ff <= sdpo_pkg::OUTPUT_SCALE_RESET;
         output_bias_ff  <= sdpo_pkg::OUTPUT_BIAS_RESET;
         valid_a_ff      <= 1'b0;
         valid_b_ff      <= 1'b0;
         valid_c_ff      <= 1'b0;
         sum_ff          <= '0;
      end else begin
         clamp_max_ff    <= clamp_max_in;
         bias_quant_ff   <= bias_quant_in;
         output_scale_ff <= output_scale_in;
         output_bias_ff  <= output_bias_in;
         valid_a_ff      <= cmd.accept;
         valid_b_ff      <= valid_a_ff;
         valid_c_ff      <= valid_b_ff;
         sum_ff          <= sum_in;
      end
   end

   assign status.pipe_empty = ~(valid_a_ff | valid_b_ff | valid_c_ff);
   assign status.div_busy   = div_busy;
   assign rsp_score         = $signed(score_ff);

endmodule

`default_nettype wire

@@ rtl/sdpo_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdpo_ctrl
// sequencer for accumulation, drain, the two divisions and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

`include "screlu_dot_product_output_macros.svh"

module sdpo_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_last,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sdpo_pkg::cmd_type          cmd,
   input  wire sdpo_pkg::status_type  status
);

   sdpo_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdpo_pkg::ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.div_sel = sdpo_pkg::SEL_SUM;
      case (state_ff)
         sdpo_pkg::ST_ACCUM: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = sdpo_pkg::ST_DRAIN;
            end
         end
         sdpo_pkg::ST_DRAIN: begin
            if (status.pipe_empty) begin
               cmd.div_start = 1'b1;
               cmd.clear_sum = 1'b1;
               state_in      = sdpo_pkg::ST_DIV1;
            end
         end
         sdpo_pkg::ST_DIV1: begin
            if (!status.div_busy) begin
               cmd.load_t1 = 1'b1;
               state_in    = sdpo_pkg::ST_SCALE;
            end
         end
         sdpo_pkg::ST_SCALE: begin
            cmd.load_t2 = 1'b1;
            state_in    = sdpo_pkg::ST_START2;
         end
         sdpo_pkg::ST_START2: begin
            cmd.div_sel   = sdpo_pkg::SEL_SCALED;
            cmd.div_start = 1'b1;
            state_in      = sdpo_pkg::ST_DIV2;
         end
         sdpo_pkg::ST_DIV2: begin
            if (!status.div_busy && out_free) begin
               cmd.load_out = 1'b1;
               state_in     = sdpo_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = sdpo_pkg::ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SDPO_ASSERT_NEXT(a_last_stops_input, clock, reset,
      req_valid && req_ready && req_last, !req_ready, "input open after last transfer")
   `SDPO_ASSERT_SAME(a_div_start_idle, clock, reset,
      cmd.div_start, !status.div_busy, "divider restarted while busy")
   `SDPO_ASSERT_SAME(a_load_out_free, clock, reset,
      cmd.load_out, out_free, "result overwritten before transfer")
   `SDPO_ASSERT_SAME(a_result_back_to_accum, clock, reset,
      $rose(rsp_valid_ff), state_ff == sdpo_pkg::ST_ACCUM, "result raised outside accumulation")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the screlu output layer: element pairs stream in,
// a scoreboard predicts each score from clamp, square, weight and scaling,
// and compares every score transfer while both sides idle at random
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_IDLE      = 12;
   localparam int SETTLE_CYCLES = 160;
   localparam int RANDOM_ITEMS  = 1280;
   localparam int RANDOM_PHASES = 6;

   logic clock = 1'b0;
   logic reset;

   logic                           req_valid;
   logic                           req_ready;
   logic signed [15:0]             req_own_value;
   logic signed [15:0]             req_other_value;
   logic signed [15:0]             req_own_weight;
   logic signed [15:0]             req_other_weight;
   logic                           req_last;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic signed [31:0]             rsp_score;
   logic                           csr_write_enable;
   logic [sdpo_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sdpo_pkg::CSR_DATA_W-1:0] csr_write_data;

   logic [14:0]        cfg_clamp;
   logic [10:0]        cfg_quant;
   logic [12:0]        cfg_scale;
   logic signed [31:0] cfg_bias;
   logic [31:0]        pair_sum;

   logic signed [31:0] expected_scores[$];
   int                 mismatch_count;
   bit                 tx_quiet;
   bit                 rx_quiet;

   screlu_dot_product_output dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_own_value    (req_own_value),
      .req_other_value  (req_other_value),
      .req_own_weight   (req_own_weight),
      .req_other_weight (req_other_weight),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_score        (rsp_score),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int draw_idle(bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic longint clamp_limit();
      return (cfg_clamp == 15'd0) ? 64'sd1 : longint'(cfg_clamp);
   endfunction

   // clamped activation squared times weight, wrapped to 32 bits
   function automatic logic [31:0] screlu_term(logic signed [15:0] v, logic signed [15:0] w);
      longint a;
      longint lim;
      lim = clamp_limit();
      a = longint'(v);
      if (a < 0) a = 0;
      if (a > lim) a = lim;
      return 32'(a * a * longint'(w));
   endfunction

   function automatic logic signed [31:0] scaled_score(logic [31:0] sum);
      longint cm;
      longint bq;
      longint t;
      cm = clamp_limit();
      bq = (cfg_quant == 11'd0) ? 64'sd1 : longint'(cfg_quant);
      t = longint'($signed(sum)) / cm + longint'(cfg_bias);
      t = t * longint'(cfg_scale);
      t = t / (cm * bq);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return 32'(t);
   endfunction

   task automatic write_csr(input sdpo_pkg::csr_index_type idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         sdpo_pkg::CSR_CLAMP_MAX:    cfg_clamp = data[14:0];
         sdpo_pkg::CSR_BIAS_QUANT:   cfg_quant = data[10:0];
         sdpo_pkg::CSR_OUTPUT_SCALE: cfg_scale = data[12:0];
         sdpo_pkg::CSR_OUTPUT_BIAS:  cfg_bias  = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] clamp, input logic [31:0] quant,
                             input logic [31:0] scale, input logic [31:0] bias);
      write_csr(sdpo_pkg::CSR_CLAMP_MAX, clamp);
      write_csr(sdpo_pkg::CSR_BIAS_QUANT, quant);
      write_csr(sdpo_pkg::CSR_OUTPUT_SCALE, scale);
      write_csr(sdpo_pkg::CSR_OUTPUT_BIAS, bias);
   endtask

   task automatic send_pair(input logic signed [15:0] own, input logic signed [15:0] other,
                            input logic signed [15:0] own_w, input logic signed [15:0] other_w,
                            input logic last);
      int idle;
      idle = draw_idle(tx_quiet);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_own_value    <= own;
      req_other_value  <= other;
      req_own_weight   <= own_w;
      req_other_weight <= other_w;
      req_last         <= last;
      do @(posedge clock); while (!req_ready);
      pair_sum = pair_sum + screlu_term(own, own_w) + screlu_term(other, other_w);
      if (last) begin
         expected_scores.push_back(scaled_score(pair_sum));
         pair_sum = '0;
      end
   endtask

   // drain every score and let the pipe and divider settle before csr writes
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // score transfer check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scores.size() == 0) begin
            $error("score: expected none, got %0d", rsp_score);
            mismatch_count++;
         end else begin
            logic signed [31:0] want;
            want = expected_scores.pop_front();
            if (rsp_score !== want) begin
               $error("score: expected %0d, got %0d", want, rsp_score);
               mismatch_count++;
            end
         end
      end
   end

   // result side backpressure
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_idle(rx_quiet);
         if (stall == 0) begin
            rsp_ready <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
         end else begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall - 1) @(posedge clock);
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [15:0] rand_activation();
      int lim;
      lim = int'(clamp_limit());
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, lim));
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         default: begin
            case ($urandom_range(0, 5))
               0: return -16'sd32768;
               1: return -16'sd1;
               2: return 16'sd0;
               3: return 16'(lim);
               4: return 16'(lim + 1);
               default: return 16'sd32767;
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [15:0] rand_weight();
      case ($urandom_range(0, 3))
         0, 1: return 16'($urandom);
         2: return 16'(int'($urandom_range(0, 16)) - 8);
         default: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_pair(16'sd100, 16'sd200, 16'sd64, -16'sd64, 1'b0);
      send_pair(16'sd255, -16'sd5, 16'sd127, 16'sd3, 1'b1);
   endtask

   task automatic test_field_extremes();
      logic signed [15:0] vals[8];
      logic signed [15:0] wts[8];
      vals = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd254, 16'sd255, 16'sd256, 16'sd32767};
      wts  = '{-16'sd32768, 16'sd32767, -16'sd1, 16'sd1, 16'sd0, 16'sd2, -16'sd2, 16'sd12345};
      wait_idle();
      set_config(32'd255, 32'd64, 32'd400, 32'd0);
      for (int i = 0; i < 8; i++)
         send_pair(vals[i], vals[7-i], wts[i], wts[7-i], (i % 4) == 3);
   endtask

   task automatic test_zero_registers();
      wait_idle();
      set_config(32'd0, 32'd0, 32'd400, -32'sd12345);
      send_pair(16'sd1, 16'sd7, 16'sd1000, -16'sd300, 1'b0);
      send_pair(-16'sd9, 16'sd32767, 16'sd5, 16'sd32767, 1'b0);
      send_pair(16'sd0, 16'sd1, 16'sd0, -16'sd32768, 1'b1);
   endtask

   task automatic test_sum_wrap();
      wait_idle();
      set_config(32'd32767, 32'd1, 32'd1, 32'd0);
      send_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
      send_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
      send_pair(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
      send_pair(16'sd32767, 16'sd20000, 16'sd32767, -16'sd32768, 1'b1);
   endtask

   task automatic test_saturation();
      wait_idle();
      set_config(32'd1, 32'd1, 32'd4096, 32'h7fff_ffff);
      send_pair(16'sd1, 16'sd1, 16'sd32767, 16'sd32767, 1'b1);
      wait_idle();
      write_csr(sdpo_pkg::CSR_OUTPUT_BIAS, 32'h8000_0000);
      send_pair(16'sd1, 16'sd1, -16'sd32768, -16'sd32768, 1'b1);
   endtask

   task automatic random_config(input int phase);
      logic [31:0] clamp, quant, scale, bias;
      case (phase)
         0: begin
            clamp = 32'd1; quant = 32'd1; scale = 32'd1; bias = 32'h8000_0000;
         end
         1: begin
            clamp = 32'd32767; quant = 32'd2047; scale = 32'd8191; bias = 32'h7fff_ffff;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: clamp = 32'd0;
               1: clamp = 32'd255;
               2: clamp = 32'd32767;
               default: clamp = $urandom_range(1, 32767);
            endcase
            case ($urandom_range(0, 3))
               0: quant = 32'd0;
               1: quant = 32'd64;
               default: quant = $urandom_range(1, 2047);
            endcase
            case ($urandom_range(0, 3))
               0: scale = 32'd0;
               1: scale = 32'd400;
               default: scale = $urandom_range(1, 8191);
            endcase
            case ($urandom_range(0, 3))
               0: bias = 32'(int'($urandom_range(0, 2000)) - 1000);
               default: bias = $urandom;
            endcase
         end
      endcase
      set_config(clamp, quant, scale, bias);
   endtask

   task automatic test_random_streams();
      int sent;
      int len;
      int per_phase;
      per_phase = RANDOM_ITEMS / RANDOM_PHASES;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         random_config(phase);
         sent = 0;
         while (sent < per_phase) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 96) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
               send_pair(rand_activation(), rand_activation(), rand_weight(), rand_weight(),
                         i == len - 1);
            sent += len;
         end
         // partial sum carried across the next csr update
         if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
               send_pair(rand_activation(), rand_activation(), rand_weight(), rand_weight(),
                         1'b0);
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      send_pair(rand_activation(), rand_activation(), rand_weight(), rand_weight(), 1'b1);
   endtask

   initial begin
      mismatch_count   = 0;
      tx_quiet         = 1'b0;
      rx_quiet         = 1'b0;
      cfg_clamp        = sdpo_pkg::CLAMP_MAX_RESET;
      cfg_quant        = sdpo_pkg::BIAS_QUANT_RESET;
      cfg_scale        = sdpo_pkg::OUTPUT_SCALE_RESET;
      cfg_bias         = sdpo_pkg::OUTPUT_BIAS_RESET;
      pair_sum         = '0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_own_value    <= '0;
      req_other_value  <= '0;
      req_own_weight   <= '0;
      req_other_weight <= '0;
      req_last         <= 1'b0;
      rsp_ready        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= sdpo_pkg::CSR_CLAMP_MAX;
      csr_write_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_zero_registers();
      test_sum_wrap();
      test_saturation();
      test_random_streams();
      wait_idle();

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
